// ===== hw/rtl/ddr_pkg.sv =====
// ----------------------------------------------------------------------------
// ddr_pkg - shared types and constants for the dead reckoning unit
// Controller states, datapath operation codes, command and status groups,
// fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddr_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 224;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
  localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;

  typedef enum logic [4:0] {
    S_IDLE, S_CORD_P, S_WAIT_P, S_MUL_VC, S_RND_AX, S_MUL_AX, S_ACC_X,
    S_MUL_VS, S_RND_AY, S_MUL_AY, S_ACC_Y, S_MUL_WE, S_ABS, S_MUL_LO,
    S_RND_B, S_MUL_HI, S_HEAD, S_CORD_Q, S_WAIT_Q, S_PUB
  } ddr_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_VEL, OP_LOAD_TICK, OP_CORD_POSE, OP_MUL_VC, OP_MUL_VS,
    OP_RND_A, OP_MUL_AE, OP_ACC_X, OP_ACC_Y, OP_MUL_WE, OP_ABS, OP_MUL_LO,
    OP_RND_B, OP_MUL_HI, OP_HEAD, OP_CORD_QUAT, OP_PUBLISH
  } ddr_op_t;

  typedef struct packed {
    ddr_op_t op;
  } ddr_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_busy;
  } ddr_status_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ddr_cordic.sv =====
// ----------------------------------------------------------------------------
// ddr_cordic - iterative rotation-mode CORDIC
// One micro-rotation per cycle; quarter-turn
// reduction before, exact quadrant fold and clamp to +-1.0 Q1.30 after.
// ----------------------------------------------------------------------------
module ddr_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);
  import ddr_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CORDIC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [33:0]      x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0]              quad_r, quad_nxt;
  logic [31:0]             rnd_angle, resid;
  logic signed [33:0]      c_raw, s_raw, atan_v;

  assign rnd_angle = angle + 32'h2000_0000;
  assign resid     = angle - {rnd_angle[31:30], 30'd0};
  assign atan_v    = atan_turn(5'(cnt_r));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = {{2{resid[31]}}, resid};
      quad_nxt = rnd_angle[31:30];
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - (y_r >>> cnt_r);
        y_nxt = y_r + (x_r >>> cnt_r);
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + (y_r >>> cnt_r);
        y_nxt = y_r - (x_r >>> cnt_r);
        z_nxt = z_r + atan_v;
      end
      if (cnt_r == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
  end

  // fold the quadrant back in
  always_comb begin
    case (quad_r)
      2'd0:    begin c_raw = x_r;  s_raw = y_r;  end
      2'd1:    begin c_raw = -y_r; s_raw = x_r;  end
      2'd2:    begin c_raw = -x_r; s_raw = -y_r; end
      default: begin c_raw = y_r;  s_raw = -x_r; end
    endcase
  end

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > ONE_Q30)       r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    else                   r = v;
    return r[31:0];
  endfunction

  assign cos_q30 = clamp_q30(c_raw);
  assign sin_q30 = clamp_q30(s_raw);
  assign done    = done_r;

endmodule

// ===== hw/rtl/ddr_datapath.sv =====
// ----------------------------------------------------------------------------
// ddr_datapath - pose state, shared multiplier and output register
// Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module ddr_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ddr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  ddr_pkg::ddr_cmd_t              cmd,
  output ddr_pkg::ddr_status_t           status,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ddr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ddr_pkg::*;

  logic signed [31:0] lin_r, ang_r, acc_x_r, acc_y_r;
  logic [23:0]        e_r;
  logic [32:0]        head_r;
  logic signed [65:0] prod_r;
  logic signed [33:0] a_r;
  logic [55:0]        m_r;
  logic               neg_r;
  logic [31:0]        b_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] rnd_a_t, rnd_d_t;
  logic signed [35:0] acc_in, acc_sum;
  logic signed [31:0] acc_sat;
  logic [65:0]        hsum;
  logic [32:0]        q33, delta;
  logic               cord_start;
  logic               cord_done;
  logic [31:0]        cord_angle;
  logic signed [31:0] cord_cos, cord_sin;

  assign cord_start = (cmd.op == OP_CORD_POSE) || (cmd.op == OP_CORD_QUAT);
  assign cord_angle = (cmd.op == OP_CORD_QUAT) ? head_r[32:1] : head_r[31:0];

  ddr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start),
    .angle   (cord_angle),
    .done    (cord_done),
    .cos_q30 (cord_cos),
    .sin_q30 (cord_sin)
  );

  always_comb begin
    mul_a = {{2{lin_r[31]}}, lin_r};
    mul_b = cord_cos;
    case (cmd.op)
      OP_MUL_VC: begin mul_a = {{2{lin_r[31]}}, lin_r}; mul_b = cord_cos; end
      OP_MUL_VS: begin mul_a = {{2{lin_r[31]}}, lin_r}; mul_b = cord_sin; end
      OP_MUL_AE: begin mul_a = a_r; mul_b = {8'd0, e_r}; end
      OP_MUL_WE: begin mul_a = {{2{ang_r[31]}}, ang_r}; mul_b = {8'd0, e_r}; end
      OP_MUL_LO: begin mul_a = {10'd0, m_r[23:0]}; mul_b = INV_TWO_PI_Q32; end
      OP_MUL_HI: begin mul_a = {2'd0, m_r[55:24]}; mul_b = INV_TWO_PI_Q32; end
      default:   begin mul_a = {{2{lin_r[31]}}, lin_r}; mul_b = cord_cos; end
    endcase
  end

  assign rnd_a_t = prod_r + 66'sd536870912;
  assign rnd_d_t = prod_r + 66'sd8388608;
  assign acc_in  = (cmd.op == OP_ACC_Y) ? {{4{acc_y_r[31]}}, acc_y_r}
                                        : {{4{acc_x_r[31]}}, acc_x_r};
  assign acc_sum = acc_in + rnd_d_t[59:24];

  always_comb begin
    if (acc_sum > 36'sh0_7FFF_FFFF)       acc_sat = 32'sh7FFF_FFFF;
    else if (acc_sum < -36'sh0_8000_0000) acc_sat = 32'sh8000_0000;
    else                                  acc_sat = acc_sum[31:0];
  end

  assign hsum  = prod_r + {34'd0, b_r};
  assign q33   = hsum[48:16];
  assign delta = neg_r ? (33'd0 - q33) : q33;

  assign status = '{cordic_done: cord_done, out_busy: out_valid_r && !out_tready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r       <= '0;
      ang_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD_VEL: begin
          lin_r <= in_tdata[31:0];
          ang_r <= in_tdata[63:32];
        end
        OP_ACC_X: acc_x_r <= acc_sat;
        OP_ACC_Y: acc_y_r <= acc_sat;
        OP_HEAD:  head_r  <= head_r + delta;
        default: ;
      endcase
      if (cmd.op == OP_PUBLISH)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_TICK: e_r <= in_tdata[87:64];
      OP_MUL_VC, OP_MUL_VS, OP_MUL_AE, OP_MUL_WE, OP_MUL_LO, OP_MUL_HI:
        prod_r <= mul_a * mul_b;
      OP_RND_A: a_r <= rnd_a_t[63:30];
      OP_ABS: begin
        neg_r <= prod_r[65];
        m_r   <= prod_r[65] ? (56'd0 - prod_r[55:0]) : prod_r[55:0];
      end
      OP_RND_B: b_r <= 32'((prod_r + 66'sd549755813888) >>> 24);
      OP_PUBLISH:
        out_data_r <= {ang_r, lin_r, cord_cos, cord_sin, head_r[31:0], acc_y_r, acc_x_r};
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/ddr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddr_ctrl - sequencing state machine
// Accepts items and steps the datapath through one tick's operations.
// ----------------------------------------------------------------------------
module ddr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tuser,
  output logic                 in_tready,
  input  ddr_pkg::ddr_status_t status,
  output ddr_pkg::ddr_cmd_t    cmd
);
  import ddr_pkg::*;

  ddr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid && in_tuser) state_nxt = S_CORD_P;
      S_CORD_P: state_nxt = S_WAIT_P;
      S_WAIT_P: if (status.cordic_done) state_nxt = S_MUL_VC;
      S_MUL_VC: state_nxt = S_RND_AX;
      S_RND_AX: state_nxt = S_MUL_AX;
      S_MUL_AX: state_nxt = S_ACC_X;
      S_ACC_X:  state_nxt = S_MUL_VS;
      S_MUL_VS: state_nxt = S_RND_AY;
      S_RND_AY: state_nxt = S_MUL_AY;
      S_MUL_AY: state_nxt = S_ACC_Y;
      S_ACC_Y:  state_nxt = S_MUL_WE;
      S_MUL_WE: state_nxt = S_ABS;
      S_ABS:    state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_RND_B;
      S_RND_B:  state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_HEAD;
      S_HEAD:   state_nxt = S_CORD_Q;
      S_CORD_Q: state_nxt = S_WAIT_Q;
      S_WAIT_Q: if (status.cordic_done) state_nxt = S_PUB;
      S_PUB:    if (!status.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = in_tuser ? OP_LOAD_TICK : OP_LOAD_VEL;
      end
      S_CORD_P: cmd.op = OP_CORD_POSE;
      S_MUL_VC: cmd.op = OP_MUL_VC;
      S_RND_AX: cmd.op = OP_RND_A;
      S_MUL_AX: cmd.op = OP_MUL_AE;
      S_ACC_X:  cmd.op = OP_ACC_X;
      S_MUL_VS: cmd.op = OP_MUL_VS;
      S_RND_AY: cmd.op = OP_RND_A;
      S_MUL_AY: cmd.op = OP_MUL_AE;
      S_ACC_Y:  cmd.op = OP_ACC_Y;
      S_MUL_WE: cmd.op = OP_MUL_WE;
      S_ABS:    cmd.op = OP_ABS;
      S_MUL_LO: cmd.op = OP_MUL_LO;
      S_RND_B:  cmd.op = OP_RND_B;
      S_MUL_HI: cmd.op = OP_MUL_HI;
      S_HEAD:   cmd.op = OP_HEAD;
      S_CORD_Q: cmd.op = OP_CORD_QUAT;
      S_PUB:    if (!status.out_busy) cmd.op = OP_PUBLISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/diff_drive_dead_reckoning_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_dead_reckoning_unit - unicycle odometry integrator
// Holds commanded velocities and integrates the pose on each time tick.
// ----------------------------------------------------------------------------
// A velocity command item (in_tuser 0) is absorbed while the controller is idle
// and gives no result. A tick item (in_tuser 1) runs two passes of the
// iterative CORDIC, and the controller is back in idle, ready for the next item,
// in the same cycle that its result is first presented. Each pass is a start
// step and then the micro-rotations, one micro-rotation a cycle. Between them a
// single shared 34x32 multiplier handles the position and heading products. The
// publish cycle waits while an earlier result is still unaccepted. A finished
// pose sits in an output register, so the next item is taken while it waits.
module diff_drive_dead_reckoning_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func
  input  logic                           in_tuser,
  // linear_velocity, angular_velocity, elapsed
  input  logic [ddr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // position_x, position_y, yaw_angle, quat_z, quat_w, echo_linear, echo_angular
  output logic [ddr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ddr_pkg::*;

  ddr_cmd_t    cmd;
  ddr_status_t status;

  ddr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ddr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/diff_drive_dead_reckoning_checker.sv =====
// ----------------------------------------------------------------------------
// diff_drive_dead_reckoning_checker - pose predictor and result scoreboard
// Watches the input and result streams, integrates the pose in fixed point on
// each accepted tick and compares every result field with the oldest pose.
// ----------------------------------------------------------------------------
module diff_drive_dead_reckoning_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic                           in_tuser,
  input  logic [ddr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [ddr_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             poses_pending
);

  localparam logic TICK = 1'b1;

  typedef struct packed {
    logic [31:0] ang;
    logic [31:0] lin;
    logic [31:0] qw;
    logic [31:0] qz;
    logic [31:0] yaw;
    logic [31:0] py;
    logic [31:0] px;
  } pose_t;

  pose_t       pose_q[$];
  longint      vel_lin, vel_ang, pos_x, pos_y;
  logic [32:0] head;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic [1:0]  quad;
    logic [31:0] res;
    longint      z, x, y, nx;
    quad = 2'((ang + 32'h2000_0000) >> 30);
    res  = ang - {quad, 30'd0};
    z = longint'($signed(res));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ddr_pkg::CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= ddr_pkg::atan_turn(5'(i));
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += ddr_pkg::atan_turn(5'(i));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clip(c, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    s = clip(s, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endtask

  function automatic longint travel(longint v, longint trig, longint e);
    longint a;
    a = asr(v * trig + (64'sd1 <<< 29), 30);
    return asr(a * e + (64'sd1 <<< 23), 24);
  endfunction

  task automatic advance(input longint e);
    longint    c, s, p, qz, qw;
    logic [63:0] m, b, q, delta;
    pose_t     r;
    sin_cos(head[31:0], c, s);
    pos_x = clip(pos_x + travel(vel_lin, c, e), -64'sd2147483648, 64'sd2147483647);
    pos_y = clip(pos_y + travel(vel_lin, s, e), -64'sd2147483648, 64'sd2147483647);
    p = vel_ang * e;
    m = p < 0 ? 64'(-p) : 64'(p);
    b = (m & 64'hFF_FFFF) * 64'd683565276 + (64'd1 << 39);
    q = ((m >> 24) * 64'd683565276 + (b >> 24)) >> 16;
    delta = p < 0 ? -q : q;
    head = head + delta[32:0];
    sin_cos(head[32:1], qw, qz);
    r.px = pos_x[31:0]; r.py = pos_y[31:0]; r.yaw = head[31:0];
    r.qz = qz[31:0]; r.qw = qw[31:0]; r.lin = vel_lin[31:0]; r.ang = vel_ang[31:0];
    pose_q.push_back(r);
  endtask

  always @(posedge clk) begin
    pose_t want, got;
    if (!rst_n) begin
      vel_lin = 0; vel_ang = 0; pos_x = 0; pos_y = 0; head = '0;
      fail_count = 0;
      pose_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pose_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = pose_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pose mismatch: exp x %h y %h yaw %h qz %h qw %h v %h w %h\n  got x %h y %h yaw %h qz %h qw %h v %h w %h",
                       want.px, want.py, want.yaw, want.qz, want.qw, want.lin, want.ang,
                       got.px, got.py, got.yaw, got.qz, got.qw, got.lin, got.ang);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == TICK) advance(longint'(in_tdata[87:64]));
        else begin
          vel_lin = longint'($signed(in_tdata[31:0]));
          vel_ang = longint'($signed(in_tdata[63:32]));
        end
      end
    end
    poses_pending = pose_q.size();
  end

endmodule

// ===== dv/diff_drive_dead_reckoning_unit_tb.sv =====
// ----------------------------------------------------------------------------
// diff_drive_dead_reckoning_unit_tb - stimulus and verdict for the odometry unit
// Drives directed items, then random ones under four gap and stall phases;
// the checker predicts every pose and counts mismatches.
// ----------------------------------------------------------------------------
module diff_drive_dead_reckoning_unit_tb;

  localparam logic VEL  = 1'b0;
  localparam logic TICK = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [223:0] out_tdata;
  int          fail_count, poses_pending;
  int          gap_pct, stall_pct;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  diff_drive_dead_reckoning_unit dut (.*);

  diff_drive_dead_reckoning_checker chk (.*);

  // random receiver stalls
  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // leave tvalid high after acceptance; drop it only for a gap or a drain
  task automatic send(input logic kind, input logic [31:0] v, input logic [31:0] w,
                      input logic [23:0] e);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {e, w, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (poses_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    gap_pct = 0; stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // zero elapsed with zero state, then extremes
    send(TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0);
    send(VEL, 32'h0001_0000, 32'h0001_0000, 24'hFFFFFF);
    send(TICK, '0, '0, 24'hFFFFFF);
    send(TICK, '0, '0, 24'd0);
    send(VEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    repeat (4) send(TICK, '0, '0, 24'hFFFFFF);
    send(VEL, 32'h8000_0000, 32'h8000_0000, '0);
    repeat (6) send(TICK, '0, '0, 24'hFFFFFF);
    send(VEL, 32'hFFFF_FFFF, 32'h0000_0001, 24'hFFFFFF);
    send(TICK, '0, '0, 24'd1);
    send(TICK, '0, '0, 24'h800000);
    // hold off until every pose is back
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1 || ph == 3) ? ((ph == 1) ? 62 : 19) : 0;
      stall_pct = (ph == 2) ? 62 : (ph == 3 ? 19 : 0);
      for (int i = 0; i < 185; i++) begin
        if ($urandom_range(3) == 0) send(VEL, pick32(), pick32(), 24'($urandom));
        else send(TICK, $urandom, $urandom,
                  $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(40000)));
      end
      if (ph == 1) drain();
    end
    drain();
    if (fail_count == 0) $display("diff_drive_dead_reckoning_unit verification clean");
    else $display("diff_drive_dead_reckoning_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("diff_drive_dead_reckoning_unit verification failed");
    $finish;
  end

endmodule
